// File: sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// shared constants and the double ordering function for the merge block
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int unsigned RUNS_DEF   = 8;
    localparam int unsigned VAL_W      = 64;
    localparam int unsigned RUN_W      = 3;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned RUN_REACH  = 8;
    localparam logic [CNT_W-1:0] RUN_COUNT_RST = 4'd2;

    localparam logic [MODE_W-1:0] MODE_VALUE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXHAUST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    // true when candidate a replaces current best b (ties go to a, nan last)
    function automatic logic takes_over(input logic [VAL_W-1:0] a,
                                        input logic [VAL_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic le;
        a_nan  = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        b_nan  = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        a_zero = (a[62:0] == 63'd0);
        b_zero = (b[62:0] == 63'd0);
        if (a_zero && b_zero)
            le = 1'b1;
        else if (a[63] != b[63])
            le = a[63];
        else if (a[63])
            le = (a[62:0] >= b[62:0]);
        else
            le = (a[62:0] <= b[62:0]);
        if (b_nan)
            takes_over = 1'b1;
        else if (a_nan)
            takes_over = 1'b0;
        else
            takes_over = le;
    endfunction

endpackage

// File: sv/kway_sorted_run_merge_top.sv
// ----------------------------------------------------------------------------
// kway_sorted_run_merge_top
// k-way merge of sorted runs of doubles into one ascending stream
// ----------------------------------------------------------------------------
// each input item either loads the next value of a run, marks a run exhausted
// or clears for a new merge. run heads live in a small ram; present and
// exhausted flags live in flops. once every run in use holds a head or is
// exhausted, one comparator walks the heads one ram read per cycle and emits
// the smallest (highest run wins on ties) and names that run for refill; when
// all runs are exhausted a single done item is emitted. an item that starts a
// scan holds off the input until the scan is through: the accepting cycle,
// a ram read for each run in use plus one more for the registered read data,
// and the load of the output register. items that cause no scan do not hold
// off the input. the result sits in an output register; while that
// register holds a stalled result the input is stalled too, and a new scan
// waits until the register is free.
module kway_sorted_run_merge_top #(
    parameter int unsigned RUNS = kwm_pkg::RUNS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [kwm_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [kwm_pkg::MODE_W-1:0] i_mode,
    input  logic [kwm_pkg::RUN_W-1:0]  i_run,
    input  logic [kwm_pkg::VAL_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [kwm_pkg::VAL_W-1:0]  o_merged_value,
    output logic [kwm_pkg::RUN_W-1:0]  o_source_run,
    output logic                       o_done_res
);
    localparam int unsigned REACH = (RUNS < kwm_pkg::RUN_REACH) ? RUNS : kwm_pkg::RUN_REACH;
    localparam int unsigned AW    = $clog2(REACH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [kwm_pkg::CNT_W-1:0] r_run_count;
    logic [RUNS-1:0] r_present;
    logic [RUNS-1:0] r_finished;
    logic            r_ended;
    logic [3:0]      r_idx;      // next ram address to read
    logic [3:0]      r_pidx;     // index of data on ram output
    logic            r_have;
    logic [kwm_pkg::VAL_W-1:0] r_best;
    logic [kwm_pkg::RUN_W-1:0] r_best_run;
    logic            r_ovalid;
    logic [kwm_pkg::VAL_W-1:0] r_oval;
    logic [kwm_pkg::RUN_W-1:0] r_orun;
    logic            r_odone;

    logic [3:0] n_use;
    logic [RUNS-1:0] in_use;
    logic accept, out_free, ram_we, upd_present, upd_finish;
    logic [RUNS-1:0] nxt_present, nxt_finished;
    logic ready_all, any_head;
    logic [kwm_pkg::VAL_W-1:0] rdata;
    logic [AW-1:0] raddr;
    logic cand;
    logic set_out;

    // runs in use: zero counts as one, saturate at the reach
    always_comb begin
        if (r_run_count == '0)
            n_use = 4'd1;
        else if ({28'd0, r_run_count} > REACH)
            n_use = 4'(REACH);
        else
            n_use = r_run_count;
        for (int i = 0; i < RUNS; i++)
            in_use[i] = (i < n_use);
    end

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign accept   = i_valid && !o_stall;

    // flag update of the accepted item
    always_comb begin
        nxt_present  = r_present;
        nxt_finished = r_finished;
        ram_we       = 1'b0;
        upd_present  = 1'b0;
        upd_finish   = 1'b0;
        if (!r_ended && {1'b0, i_run} < n_use) begin
            if (i_mode == kwm_pkg::MODE_VALUE) begin
                if (!r_finished[i_run[AW-1:0]] && !r_present[i_run[AW-1:0]]) begin
                    ram_we      = accept;
                    upd_present = 1'b1;
                    nxt_present[i_run[AW-1:0]] = 1'b1;
                end
            end else if (i_mode == kwm_pkg::MODE_EXHAUST) begin
                upd_finish = 1'b1;
                nxt_finished[i_run[AW-1:0]] = 1'b1;
            end
        end
        ready_all = &((nxt_present | nxt_finished) | ~in_use);
        any_head  = |(nxt_present & in_use);
    end

    assign raddr = r_idx[AW-1:0];

    kwm_ram #(.WIDTH(kwm_pkg::VAL_W), .DEPTH(REACH)) u_heads (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_run[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cand = r_present[r_pidx[AW-1:0]] &&
                  (!r_have || kwm_pkg::takes_over(rdata, r_best));

    // output register loads the done item or the winner of a scan
    assign set_out = (r_state == S_IDLE && accept && i_mode != kwm_pkg::MODE_CLEAR
                      && !r_ended && ready_all && !any_head && out_free)
                     || (r_state == S_LAST && out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && i_mode != kwm_pkg::MODE_CLEAR && !r_ended
                        && ready_all && any_head)
                        n_state = S_SCAN;
            S_SCAN: if (r_idx == n_use) n_state = S_LAST;
            S_LAST: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_count <= kwm_pkg::RUN_COUNT_RST;
            r_present   <= '0;
            r_finished  <= '0;
            r_ended     <= 1'b0;
            r_ovalid    <= 1'b0;
            r_idx       <= '0;
            r_pidx      <= '0;
            r_have      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we)
                r_run_count <= i_cfg_wdata;
            if (set_out)
                r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall)
                r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_have <= 1'b0;
                    if (accept) begin
                        if (i_mode == kwm_pkg::MODE_CLEAR) begin
                            r_present  <= '0;
                            r_finished <= '0;
                            r_ended    <= 1'b0;
                        end else if (!r_ended) begin
                            if (upd_present) r_present <= nxt_present;
                            if (upd_finish)  r_finished <= nxt_finished;
                            if (ready_all && !any_head && out_free) begin
                                r_ended  <= 1'b1;
                                r_oval   <= '0;
                                r_orun   <= '0;
                                r_odone  <= 1'b1;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_idx  <= r_idx + 4'd1;
                    r_pidx <= r_idx;
                    if (r_idx != 4'd0 && cand) begin
                        r_have     <= 1'b1;
                        r_best     <= rdata;
                        r_best_run <= r_pidx[kwm_pkg::RUN_W-1:0];
                    end
                end
                S_LAST: begin
                    if (out_free) begin
                        r_odone  <= 1'b0;
                        r_present[r_best_run[AW-1:0]] <= 1'b0;
                        r_oval   <= r_best;
                        r_orun   <= r_best_run;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_merged_value = r_oval;
    assign o_source_run   = r_orun;
    assign o_done_res     = r_odone;

`ifndef SYNTHESIS
    // a scan only runs while some head is held
    a_scan_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_present != '0))
        else $error("scan without any head");
    // the emitted run always held a head when the scan ended
    a_best_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST && out_free) |-> r_have)
        else $error("scan ended without a candidate");
    // done only after the merge ended
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> r_ended)
        else $error("done item without merge end");
`endif
endmodule

// File: sv/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// generic single-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
